FILE: src/urc_pkg.sv
package urc_pkg;

   // Sizing defaults for the top level
   localparam int TABLE_ENTRIES_DEFAULT = 6;
   localparam int MAX_UDP_BYTES_DEFAULT = 1480;

   // Fixed frame offsets (Ethernet + IPv4 without options + UDP)
   localparam int PROTO_POS    = 23;
   localparam int IP_SRC_POS   = 26;
   localparam int IP_DST_LAST  = 33;
   localparam int UDP_START    = 34;
   localparam int PORT_LO_POS  = 37;
   localparam int LEN_LO_POS   = 39;
   localparam int CSUM_HI_POS  = 40;
   localparam int CSUM_LO_POS  = 41;
   localparam int PAYLOAD_POS  = 42;

   localparam logic [7:0]  UDP_PROTO    = 8'd17;
   localparam logic [15:0] PORT_RESET   = 16'd51141;
   localparam logic [15:0] PSEUDO_PROTO = 16'h0011;

   // Table keys and the inserted response
   localparam logic [7:0] KEY_SIZE    = 8'h00;
   localparam logic [7:0] KEY_NEWLINE = 8'h0a;
   localparam logic [7:0] RESP_P      = 8'h70;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic        verdict;
      logic [7:0]  reply_byte;
      logic [15:0] udp_checksum;
      logic [31:0] match_count;
   } rsp_type;

   // Summary of a finished frame, handed from the parser to the table
   typedef struct packed {
      logic        qualified;
      logic        long_frame;
      logic [7:0]  key;
      logic [31:0] acc;
      logic [15:0] extra;
   } fin_type;

endpackage

FILE: src/udp_reply_cache_checksum.sv
// Channel  Dir  Handshake                Word
// req      in   req_valid / req_stall    req_type: frame_byte, frame_end
// rsp      out  rsp_valid / rsp_stall    rsp_type: verdict, reply_byte,
//                                        udp_checksum, match_count
// csr      in   csr_valid / csr_ready    match_port (16 bits)
//
// One frame byte is taken each cycle req_stall is low. A final byte's result
// passes the summary and output registers; other bytes give no result.
// The table lookup and checksum fold sit in the stage after the byte parser.
// Synchronous reset; the table comes up with keys 0 and 10, no clearing pass.
// req_stall rises only when a final byte meets a held summary and a held result.
module udp_reply_cache_checksum
   import urc_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int MAX_UDP_BYTES = MAX_UDP_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic        req_valid_ff;
   req_type     req_ff;
   logic        fin_valid_ff;
   fin_type     fin_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [15:0] port_ff;

   fin_type     fin_in;
   rsp_type     rsp_in;
   logic        rsp_free;
   logic        fin_move;
   logic        fin_free;
   logic        parse_move;

   // Flow control between the three stages
   always_comb begin
      rsp_free   = !rsp_valid_ff || !rsp_stall;
      fin_move   = fin_valid_ff && rsp_free;
      fin_free   = !fin_valid_ff || fin_move;
      parse_move = req_valid_ff && (!req_ff.frame_end || fin_free);
   end

   assign req_stall = req_valid_ff && !parse_move;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign csr_ready = 1'b1;

   // Port register
   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff <= PORT_RESET;
      end else if (csr_valid) begin
         port_ff <= csr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_valid_ff || parse_move) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_valid_ff || parse_move) begin
         req_ff <= req_word;
      end
   end

   urc_parse #(
      .MAX_UDP_BYTES (MAX_UDP_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (parse_move),
      .word       (req_ff),
      .match_port (port_ff),
      .fin        (fin_in)
   );

   // Frame summary register
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_free) begin
         fin_valid_ff <= parse_move && req_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_free) begin
         fin_ff <= fin_in;
      end
   end

   urc_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .update (fin_move),
      .fin    (fin_ff),
      .result (rsp_in)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // only a final byte is ever held back
   a_stall_only_final: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && req_ff.frame_end)
      else $error("input held on a non-final byte");

   // a summary waiting on the output is not dropped
   a_fin_kept: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !fin_move |=> fin_valid_ff)
      else $error("frame summary lost");

   // a summary that moves shows up as a result
   a_fin_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fin_move |=> rsp_valid_ff)
      else $error("frame summary produced no result");

   // pass verdicts carry zero reply fields
   a_pass_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.verdict |->
         rsp_ff.reply_byte == 8'h00 && rsp_ff.udp_checksum == 16'h0000)
      else $error("pass verdict with reply fields set");
`endif

endmodule

FILE: src/urc_parse.sv
module urc_parse
   import urc_pkg::*;
#(
   parameter int MAX_UDP_BYTES = MAX_UDP_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     word,
   input  logic [15:0] match_port,
   output fin_type     fin
);

   localparam int PosCap = UDP_START + MAX_UDP_BYTES;
   localparam int PosW   = $clog2(PosCap + 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic [31:0]     acc_ff, acc_in;
   logic            udp_ff, udp_in;
   logic            port_ff, port_in;
   logic            pend_ff, pend_in;
   logic [7:0]      pend_byte_ff, pend_byte_in;
   logic [7:0]      chosen_ff, chosen_in;

   logic [7:0]      byte_val;
   logic [15:0]     sum_word;
   logic            in_ip;
   logic            in_udp;

   // Per-byte update of the running frame state
   always_comb begin
      in_ip  = (pos_ff >= PosW'(IP_SRC_POS)) && (pos_ff <= PosW'(IP_DST_LAST));
      in_udp = (pos_ff >= PosW'(UDP_START)) && (pos_ff < PosW'(PosCap));

      // checksum field and first payload byte count as zero
      if (pos_ff == PosW'(CSUM_HI_POS) || pos_ff == PosW'(CSUM_LO_POS) ||
          pos_ff == PosW'(PAYLOAD_POS)) begin
         byte_val = 8'h00;
      end else begin
         byte_val = word.frame_byte;
      end
      sum_word = {pend_byte_ff, byte_val};

      pos_in       = pos_ff;
      acc_in       = acc_ff;
      udp_in       = udp_ff;
      port_in      = port_ff;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      chosen_in    = chosen_ff;

      if (pos_ff == PosW'(PROTO_POS) && word.frame_byte == UDP_PROTO) begin
         udp_in = 1'b1;
      end

      if (in_ip || in_udp) begin
         if (pos_ff == PosW'(PAYLOAD_POS)) begin
            chosen_in = word.frame_byte;
         end
         if (!pos_ff[0]) begin
            pend_byte_in = byte_val;
            pend_in      = 1'b1;
         end else begin
            // length word counts twice: once in the pseudo-header
            if (pos_ff == PosW'(LEN_LO_POS)) begin
               acc_in = acc_ff + {15'b0, sum_word, 1'b0};
            end else begin
               acc_in = acc_ff + {16'b0, sum_word};
            end
            if (pos_ff == PosW'(PORT_LO_POS) && sum_word == match_port) begin
               port_in = 1'b1;
            end
            pend_in = 1'b0;
         end
      end

      if (pos_ff < PosW'(PosCap)) begin
         pos_in = pos_ff + PosW'(1);
      end
   end

   // Frame summary, meaningful on the final byte
   always_comb begin
      fin.qualified  = (pos_ff >= PosW'(CSUM_LO_POS)) && udp_in && port_in;
      fin.long_frame = (pos_ff >= PosW'(PAYLOAD_POS));
      fin.key        = chosen_in;
      fin.acc        = acc_in;
      fin.extra      = PSEUDO_PROTO + (pend_in ? {pend_byte_in, 8'h00} : 16'h0000);
   end

   // Frame state registers, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset || (step && word.frame_end)) begin
         pos_ff       <= '0;
         acc_ff       <= '0;
         udp_ff       <= 1'b0;
         port_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         pend_byte_ff <= '0;
         chosen_ff    <= '0;
      end else if (step) begin
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         udp_ff       <= udp_in;
         port_ff      <= port_in;
         pend_ff      <= pend_in;
         pend_byte_ff <= pend_byte_in;
         chosen_ff    <= chosen_in;
      end
   end

endmodule

FILE: src/urc_table.sv
module urc_table
   import urc_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    update,
   input  fin_type fin,
   output rsp_type result
);

   logic        valid_ff [TABLE_ENTRIES];
   logic [7:0]  key_ff   [TABLE_ENTRIES];
   logic [31:0] count_ff [TABLE_ENTRIES];
   logic [7:0]  resp_ff  [TABLE_ENTRIES];
   logic [31:0] matched_ff;

   logic [TABLE_ENTRIES-1:0] hit_vec, sz_vec, nl_vec, free_vec;
   logic [TABLE_ENTRIES-1:0] hit_oh, sz_oh, nl_oh, free_oh;
   logic [7:0]  hit_resp;
   logic [31:0] sz_count;
   logic        hit_any;
   logic        rule_go;
   logic        frame_go;
   logic [31:0] sum0;
   logic [16:0] fold1;
   logic [16:0] fold2;

   // Parallel key compare in every entry
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i]  = valid_ff[i] && (key_ff[i] == fin.key);
         sz_vec[i]   = valid_ff[i] && (key_ff[i] == KEY_SIZE);
         nl_vec[i]   = valid_ff[i] && (key_ff[i] == KEY_NEWLINE);
         free_vec[i] = !valid_ff[i];
      end
      // lowest matching slot wins
      hit_oh  = hit_vec & (~hit_vec + TABLE_ENTRIES'(1));
      sz_oh   = sz_vec & (~sz_vec + TABLE_ENTRIES'(1));
      nl_oh   = nl_vec & (~nl_vec + TABLE_ENTRIES'(1));
      free_oh = free_vec & (~free_vec + TABLE_ENTRIES'(1));
   end

   // One-hot reads of the selected entries
   always_comb begin
      hit_resp = '0;
      sz_count = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_resp = hit_resp | (hit_oh[i] ? resp_ff[i] : 8'h00);
         sz_count = sz_count | (sz_oh[i] ? count_ff[i] : 32'h0);
      end
      hit_any  = |hit_vec;
      frame_go = fin.qualified && fin.long_frame;
      rule_go  = (|sz_vec) && (|nl_vec) &&
                 ($signed(sz_count) < $signed(32'(TABLE_ENTRIES)));
   end

   // Checksum with the reply byte in place, folded twice and inverted
   always_comb begin
      sum0  = fin.acc + {16'h0, fin.extra} + {16'h0, hit_resp, 8'h00};
      fold1 = {1'b0, sum0[15:0]} + {1'b0, sum0[31:16]};
      fold2 = {1'b0, fold1[15:0]} + {16'h0, fold1[16]};

      result.verdict      = frame_go && hit_any;
      result.reply_byte   = result.verdict ? hit_resp : 8'h00;
      result.udp_checksum = result.verdict ? ~fold2[15:0] : 16'h0000;
      result.match_count  = matched_ff + {31'b0, fin.qualified};
   end

   // Matched frame counter
   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff <= '0;
      end else if (update && fin.qualified) begin
         matched_ff <= matched_ff + 32'd1;
      end
   end

   // Table entries
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
      logic        valid_in;
      logic [7:0]  key_in;
      logic [31:0] count_in;
      logic [7:0]  resp_in;

      always_comb begin
         valid_in = valid_ff[g];
         key_in   = key_ff[g];
         count_in = count_ff[g];
         resp_in  = resp_ff[g];
         if (update && frame_go) begin
            if (hit_any) begin
               if (hit_oh[g]) begin
                  count_in = count_ff[g] + 32'd1;
               end
            end else if (rule_go) begin
               if (sz_oh[g]) begin
                  count_in = count_ff[g] + 32'd1;
                  resp_in  = RESP_P;
               end
               if (nl_oh[g]) begin
                  resp_in = fin.key;
               end
               // new entry copies the bumped size entry
               if (free_oh[g]) begin
                  valid_in = 1'b1;
                  key_in   = fin.key;
                  count_in = sz_count + 32'd1;
                  resp_in  = RESP_P;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= (g == 0) || (g == 1);
            key_ff[g]   <= (g == 1) ? KEY_NEWLINE : KEY_SIZE;
            count_ff[g] <= '0;
            resp_ff[g]  <= '0;
         end else begin
            valid_ff[g] <= valid_in;
            key_ff[g]   <= key_in;
            count_ff[g] <= count_in;
            resp_ff[g]  <= resp_in;
         end
      end
   end

endmodule
